FILE: rtl/fpcc_pkg.sv
package fpcc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CRC_W   = 32;
  localparam int unsigned CHECK_W = 32;
  localparam int unsigned MODE_W  = 2;

  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

  // check_mode codes; bit 1 set selects CRC (the fourth code acts as CRC too)
  localparam logic [MODE_W-1:0] MODE_EVEN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ODD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CRC  = 2'd2;
  localparam int unsigned MODE_CRC_BIT = 1;
  localparam int unsigned MODE_ODD_BIT = 0;

  // register index, taken from paddr[2]
  localparam logic REG_CHECK_MODE  = 1'b0;
  localparam logic REG_VERIFY_MODE = 1'b1;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef struct packed {
    logic [MODE_W-1:0] check_mode;
    logic              verify_mode;
  } cfg_t;

  typedef struct packed {
    logic              error_found;
    logic [CHECK_W-1:0] check_bits;
  } result_t;

  // Reflected CRC-32 over one byte, LSB first: eight shift/xor steps.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc_in;
    for (int k = 0; k < BYTE_W; k++) begin
      fb = c[0] ^ data[k];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/fpcc_regs.sv
module fpcc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fpcc_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [fpcc_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [fpcc_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output fpcc_pkg::cfg_t               cfg
);

  logic [fpcc_pkg::MODE_W-1:0] check_mode_r;
  logic                        verify_mode_r;
  logic                        wr_en;
  logic                        reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_mode_r  <= fpcc_pkg::MODE_CRC;
      verify_mode_r <= 1'b0;
    end else if (wr_en) begin
      if (reg_sel == fpcc_pkg::REG_CHECK_MODE) begin
        check_mode_r <= cfg_pwdata[fpcc_pkg::MODE_W-1:0];
      end else begin
        verify_mode_r <= cfg_pwdata[0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_sel == fpcc_pkg::REG_CHECK_MODE) begin
      cfg_prdata[fpcc_pkg::MODE_W-1:0] = check_mode_r;
    end else begin
      cfg_prdata[0] = verify_mode_r;
    end
  end

  assign cfg.check_mode  = check_mode_r;
  assign cfg.verify_mode = verify_mode_r;

endmodule

FILE: rtl/fpcc_core.sv
module fpcc_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fpcc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fpcc_pkg::BYTE_W-1:0]   in_byte,
  input  logic                          in_last,
  input  logic [fpcc_pkg::CHECK_W-1:0]  in_rx,
  output logic                          res_valid,
  input  logic                          res_ready,
  output fpcc_pkg::result_t             res
);

  logic                          beat_v_r;
  logic [fpcc_pkg::BYTE_W-1:0]   byte_r;
  logic                          last_r;
  logic [fpcc_pkg::CHECK_W-1:0]  rx_r;
  logic [fpcc_pkg::CRC_W-1:0]    crc_r, crc_nxt;
  logic                          par_r, par_nxt;
  logic [fpcc_pkg::CRC_W-1:0]    crc_upd;
  logic                          par_upd;
  logic                          adv;

  // advance the held beat; a last beat also needs room for its result
  assign adv      = beat_v_r & (~last_r | res_ready);
  assign in_ready = ~beat_v_r | adv;

  assign crc_upd = fpcc_pkg::crc_byte(crc_r, byte_r);
  assign par_upd = par_r ^ (^byte_r);

  always_comb begin
    crc_nxt = crc_r;
    par_nxt = par_r;
    if (adv) begin
      crc_nxt = last_r ? fpcc_pkg::CRC_INIT : crc_upd;
      par_nxt = last_r ? 1'b0 : par_upd;
    end
  end

  always_comb begin
    res = '0;
    if (cfg.check_mode[fpcc_pkg::MODE_CRC_BIT]) begin
      res.check_bits  = ~crc_upd;
      res.error_found = cfg.verify_mode & (res.check_bits != rx_r);
    end else begin
      res.check_bits[0] = par_upd ^ cfg.check_mode[fpcc_pkg::MODE_ODD_BIT];
      res.error_found   = cfg.verify_mode & (res.check_bits[0] != rx_r[0]);
    end
  end

  assign res_valid = beat_v_r & last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_v_r <= 1'b0;
      crc_r    <= fpcc_pkg::CRC_INIT;
      par_r    <= 1'b0;
    end else begin
      crc_r <= crc_nxt;
      par_r <= par_nxt;
      if (in_ready) begin
        beat_v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
      last_r <= in_last;
      rx_r   <= in_rx;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last_r |=> (crc_r == fpcc_pkg::CRC_INIT) && !par_r)
    else $error("running check state not restarted after frame end");

  a_err_only_verify: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.error_found |-> cfg.verify_mode)
    else $error("error flagged outside verify mode");

  a_parity_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !cfg.check_mode[fpcc_pkg::MODE_CRC_BIT] |->
      (res.check_bits[fpcc_pkg::CHECK_W-1:1] == '0))
    else $error("parity result carries upper bits");

endmodule

FILE: rtl/fpcc_out_buf.sv
module fpcc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  fpcc_pkg::result_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output fpcc_pkg::result_t pop_data
);

  logic              main_v_r, skid_v_r;
  fpcc_pkg::result_t main_d_r, skid_d_r;
  logic              pop;
  logic              push;

  assign push_ready = ~skid_v_r;
  assign push       = push_valid & push_ready;
  assign pop        = main_v_r & pop_ready;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_d_r <= push_data;
      end else begin
        skid_d_r <= push_data;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held without a head entry");

endmodule

FILE: rtl/frame_parity_crc32_checker_unit.sv
// Channel  | Ports                          | Beat contents (low bit up)
// in       | in_tvalid/in_tready/in_tdata   | data_byte[7:0], received_check[39:8]
//          | in_tlast                       | last
// out      | out_tvalid/out_tready/out_tdata| check_bits[31:0], error_found[32], zero
// cfg      | cfg_psel..cfg_pready (APB)     | 0x0 check_mode, 0x4 verify_mode
//
// Takes one byte per cycle while in_tready is high; the CRC byte step is one unrolled XOR network.
// A frame result is formed from the held last byte and registered in the result buffer before it leaves.
// Synchronous active-low reset restores CRC all ones, parity zero, modes.
// A stalled out channel holds its beat; the two-entry result buffer holds two
// waiting results, and non-last bytes keep flowing. A frame end that finds
// the buffer full holds in_tready low until out_tready frees an entry.
module frame_parity_crc32_checker_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [39:0]                  in_tdata,   // data_byte[7:0], received_check[39:8]
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [39:0]                  out_tdata,  // check_bits[31:0], error_found[32], 0
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fpcc_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [fpcc_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [fpcc_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  fpcc_pkg::cfg_t    cfg;
  fpcc_pkg::result_t res;
  fpcc_pkg::result_t out_res;
  logic              res_valid;
  logic              res_ready;

  // mode registers, read and written over APB, feeding the running check logic
  fpcc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // hold each byte, fold it into CRC and parity, form the result on last
  fpcc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata[7:0]),
    .in_last   (in_tlast),
    .in_rx     (in_tdata[39:8]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // register results and hold up to two of them under out_tready back-pressure
  fpcc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_ready (res_ready),
    .push_data  (res),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (out_res)
  );

  assign out_tdata = {7'b0, out_res.error_found, out_res.check_bits};

endmodule
